### hw/rtl/vpb_pkg.sv
// ---------------------------------------------------------------------------
// vpb_pkg
// shared types and constants of the visibility pregrid and w-plane binner
// ---------------------------------------------------------------------------
package vpb_pkg;

    localparam int PLANES      = 32;
    localparam int GRID_SIZE   = 4096;
    localparam int OVERSAMPLE  = 8;
    localparam int MAX_RESULTS = 32;

    localparam int CELL_W  = 12;
    localparam int FRAC_W  = 3;
    localparam int PLANE_W = 5;
    localparam int BL_W    = 16;
    localparam int CNT_W   = 24;
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // serial multiplier operand widths
    localparam int MUL_A_W = 128;
    localparam int MUL_B_W = 64;
    localparam int MUL_C_W = $clog2(MUL_B_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_IW    = 1;

    // register indexes
    localparam logic [2:0] REG_COORD_SCALE = 3'd0;
    localparam logic [2:0] REG_UV_OFFSET   = 3'd1;
    localparam logic [2:0] REG_W_OFFSET    = 3'd2;
    localparam logic [2:0] REG_CHAN_RATIO  = 3'd3;
    localparam logic [2:0] REG_INV_STEP    = 3'd4;

    // command and result kind codes
    localparam logic CMD_POINT  = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;
    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef struct packed {
        logic [31:0] scale;
        logic [31:0] uv_off;
        logic [31:0] w_off;
        logic [31:0] ratio;
        logic [31:0] inv_step;
    } cfg_t;

    typedef struct packed {
        logic               cmd;
        logic [CELL_W-1:0]  gu;
        logic [CELL_W-1:0]  gv;
        logic [FRAC_W-1:0]  fu;
        logic [FRAC_W-1:0]  fv;
        logic [PLANE_W-1:0] pl;
        logic [BL_W-1:0]    bl;
    } item_t;

endpackage

### hw/rtl/vpb_mul.sv
// ---------------------------------------------------------------------------
// vpb_mul
// shift-and-add unsigned multiplier, one multiplier bit per cycle
// ---------------------------------------------------------------------------
module vpb_mul (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vpb_pkg::MUL_A_W-1:0] a,
    input  logic [vpb_pkg::MUL_B_W-1:0] b,
    output logic                        done,
    output logic [vpb_pkg::MUL_A_W-1:0] product
);

    logic [vpb_pkg::MUL_A_W-1:0] a_reg;
    logic [vpb_pkg::MUL_B_W-1:0] b_reg;
    logic [vpb_pkg::MUL_A_W-1:0] acc_reg;
    logic [vpb_pkg::MUL_C_W-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vpb_pkg::MUL_C_W'(vpb_pkg::MUL_B_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hw/rtl/vpb_fifo.sv
// ---------------------------------------------------------------------------
// vpb_fifo
// short queue of classified items between front and back
// ---------------------------------------------------------------------------
module vpb_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vpb_pkg::item_t push_data,
    output logic           full,
    input  logic           pop,
    output vpb_pkg::item_t head,
    output logic           empty
);

    vpb_pkg::item_t                mem_reg [vpb_pkg::FIFO_DEPTH];
    logic [vpb_pkg::FIFO_IW-1:0]   wptr_reg;
    logic [vpb_pkg::FIFO_IW-1:0]   rptr_reg;
    logic [vpb_pkg::FIFO_IW:0]     fill_reg;

    assign full  = (fill_reg == (vpb_pkg::FIFO_IW + 1)'(vpb_pkg::FIFO_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = mem_reg[rptr_reg];

    // pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/vpb_front.sv
// ---------------------------------------------------------------------------
// vpb_front
// accepts items, scales coordinates and derives cell, fraction and plane
// ---------------------------------------------------------------------------
module vpb_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  vpb_pkg::cfg_t               cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_command,
    input  logic signed [31:0]          s_coord_u,
    input  logic signed [31:0]          s_coord_v,
    input  logic signed [31:0]          s_coord_w,
    input  logic [15:0]                 s_channel_index,
    input  logic [15:0]                 s_baseline_id,
    output logic                        push,
    output vpb_pkg::item_t              push_data,
    input  logic                        full
);

    localparam logic [3:0] F_IDLE  = 4'd0;
    localparam logic [3:0] F_CH    = 4'd1;
    localparam logic [3:0] F_START = 4'd2;
    localparam logic [3:0] F_M1    = 4'd3;
    localparam logic [3:0] F_AFF   = 4'd4;
    localparam logic [3:0] F_M2    = 4'd5;
    localparam logic [3:0] F_POST  = 4'd6;
    localparam logic [3:0] F_M3    = 4'd7;
    localparam logic [3:0] F_WPOST = 4'd8;
    localparam logic [3:0] F_PUSH  = 4'd9;

    localparam logic [1:0] K_U = 2'd0;
    localparam logic [1:0] K_V = 2'd1;
    localparam logic [1:0] K_W = 2'd2;

    logic [3:0]         state_reg;
    logic [1:0]         k_reg;
    logic               cmd_reg;
    logic signed [31:0] cu_reg, cv_reg, cw_reg;
    logic [15:0]        ch_reg;
    logic [15:0]        bl_reg;
    logic [48:0]        c_reg;
    logic               neg_reg;
    logic               pos_reg;
    logic [vpb_pkg::CELL_W-1:0]  gu_reg, gv_reg;
    logic [vpb_pkg::FRAC_W-1:0]  fu_reg, fv_reg;
    logic [vpb_pkg::PLANE_W-1:0] pl_reg;

    logic                        mul_start;
    logic [vpb_pkg::MUL_A_W-1:0] mul_a;
    logic [vpb_pkg::MUL_B_W-1:0] mul_b;
    logic                        mul_done;
    logic [vpb_pkg::MUL_A_W-1:0] mul_p;

    vpb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    // coordinate of the current pass and its magnitude
    logic signed [31:0] coord;
    logic [31:0]        coord_mag;
    always_comb begin
        case (k_reg)
            K_U:     coord = cu_reg;
            K_V:     coord = cv_reg;
            default: coord = cw_reg;
        endcase
        coord_mag = coord[31] ? (~coord + 32'd1) : coord;
    end

    // affine step: floor to Q.16 with sign, then add offset
    logic [63:0]        t_val;
    logic [64:0]        t_rnd;
    logic [56:0]        t_q;
    logic signed [58:0] f_val;
    logic [31:0]        off;
    logic signed [58:0] a_val;
    always_comb begin
        t_val = mul_p[63:0];
        t_rnd = {1'b0, t_val} + 65'd255;
        t_q   = neg_reg ? t_rnd[64:8] : {1'b0, t_val[63:8]};
        f_val = neg_reg ? -$signed({2'b00, t_q}) : $signed({2'b00, t_q});
        off   = (k_reg == K_W) ? cfg.w_off : cfg.uv_off;
        a_val = f_val + $signed({{27{off[31]}}, off});
    end

    // cell and fraction of the full product
    logic [vpb_pkg::CELL_W-1:0] cell_idx;
    logic [vpb_pkg::FRAC_W-1:0] frac;
    logic [52:0]                fr_full;
    logic                       cell_sat;
    always_comb begin
        fr_full  = 53'(mul_p[45:0]) * 53'(vpb_pkg::OVERSAMPLE);
        cell_sat = (mul_p[127:46] >= 82'(vpb_pkg::GRID_SIZE));
        if (!pos_reg) begin
            cell_idx = '0;
            frac     = '0;
        end else if (cell_sat) begin
            cell_idx = vpb_pkg::CELL_W'(vpb_pkg::GRID_SIZE - 1);
            frac     = '0;
        end else begin
            cell_idx = mul_p[46 +: vpb_pkg::CELL_W];
            frac     = vpb_pkg::FRAC_W'(fr_full >> 46);
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign push    = (state_reg == F_PUSH) && !full;

    always_comb begin
        push_data    = '0;
        push_data.cmd = cmd_reg;
        push_data.gu = gu_reg;
        push_data.gv = gv_reg;
        push_data.fu = fu_reg;
        push_data.fv = fv_reg;
        push_data.pl = pl_reg;
        push_data.bl = bl_reg;
    end

    // multiplier launch
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            F_START: begin
                mul_start = 1'b1;
                mul_a     = vpb_pkg::MUL_A_W'(coord_mag);
                mul_b     = vpb_pkg::MUL_B_W'(cfg.scale);
            end
            F_AFF: begin
                mul_start = !a_val[58] && (a_val != '0);
                mul_a     = vpb_pkg::MUL_A_W'(a_val[57:0]);
                mul_b     = vpb_pkg::MUL_B_W'(c_reg);
            end
            F_POST: begin
                mul_start = (k_reg == K_W) && pos_reg && (cfg.inv_step != '0)
                            && (mul_p[127:63] == '0);
                mul_a     = vpb_pkg::MUL_A_W'(mul_p[62:30]);
                mul_b     = vpb_pkg::MUL_B_W'(cfg.inv_step);
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            k_reg     <= K_U;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        k_reg     <= K_U;
                        state_reg <= (s_command == vpb_pkg::CMD_FLUSH) ? F_PUSH : F_CH;
                    end
                end
                F_CH:    state_reg <= F_START;
                F_START: state_reg <= F_M1;
                F_M1: begin
                    if (mul_done) begin
                        state_reg <= F_AFF;
                    end
                end
                F_AFF: begin
                    state_reg <= (!a_val[58] && (a_val != '0)) ? F_M2 : F_POST;
                end
                F_M2: begin
                    if (mul_done) begin
                        state_reg <= F_POST;
                    end
                end
                F_POST: begin
                    if (k_reg != K_W) begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= F_START;
                    end else begin
                        state_reg <= mul_start ? F_M3 : F_PUSH;
                    end
                end
                F_M3: begin
                    if (mul_done) begin
                        state_reg <= F_WPOST;
                    end
                end
                F_WPOST: state_reg <= F_PUSH;
                F_PUSH: begin
                    if (!full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd_reg <= s_command;
            cu_reg  <= s_coord_u;
            cv_reg  <= s_coord_v;
            cw_reg  <= s_coord_w;
            ch_reg  <= s_channel_index;
            bl_reg  <= s_baseline_id;
            gu_reg  <= '0;
            gv_reg  <= '0;
            fu_reg  <= '0;
            fv_reg  <= '0;
            pl_reg  <= '0;
        end
        if (state_reg == F_CH) begin
            c_reg <= 49'(64'd1 << 30) + 49'(ch_reg) * 49'(cfg.ratio);
        end
        if (state_reg == F_START) begin
            neg_reg <= coord[31];
        end
        if (state_reg == F_AFF) begin
            pos_reg <= !a_val[58] && (a_val != '0);
        end
        if (state_reg == F_POST) begin
            unique case (k_reg)
                K_U: begin
                    gu_reg <= cell_idx;
                    fu_reg <= frac;
                end
                K_V: begin
                    gv_reg <= cell_idx;
                    fv_reg <= frac;
                end
                default: begin
                    if (!pos_reg || cfg.inv_step == '0) begin
                        pl_reg <= '0;
                    end else if (mul_p[127:63] != '0) begin
                        pl_reg <= vpb_pkg::PLANE_W'(vpb_pkg::PLANES - 1);
                    end
                end
            endcase
        end
        if (state_reg == F_WPOST) begin
            if (mul_p[127:32] >= 96'(vpb_pkg::PLANES)) begin
                pl_reg <= vpb_pkg::PLANE_W'(vpb_pkg::PLANES - 1);
            end else begin
                pl_reg <= mul_p[32 +: vpb_pkg::PLANE_W];
            end
        end
    end

endmodule

### hw/rtl/vpb_back.sv
// ---------------------------------------------------------------------------
// vpb_back
// per-plane run table, descriptor and point emission, flush scan
// ---------------------------------------------------------------------------
module vpb_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        empty,
    input  vpb_pkg::item_t              head,
    output logic                        pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [11:0]                 m_grid_u,
    output logic [11:0]                 m_grid_v,
    output logic [4:0]                  m_plane_index,
    output logic [2:0]                  m_frac_u,
    output logic [2:0]                  m_frac_v,
    output logic [15:0]                 m_run_baseline,
    output logic [23:0]                 m_run_count,
    output logic                        m_last
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_PT   = 2'd1;
    localparam logic [1:0] B_FL   = 2'd2;

    logic [1:0]                      state_reg;
    vpb_pkg::item_t                  cur_reg;
    logic [vpb_pkg::PLANE_W-1:0]     scan_reg;
    logic [vpb_pkg::NRES_W-1:0]      nres_reg;
    logic [vpb_pkg::PLANES-1:0]      open_reg;
    logic [vpb_pkg::BL_W-1:0]        base_reg [vpb_pkg::PLANES];
    logic [vpb_pkg::CNT_W-1:0]       cnt_reg  [vpb_pkg::PLANES];

    logic                            m_valid_reg;
    logic                            kind_reg, last_reg;
    logic [vpb_pkg::CELL_W-1:0]      gu_reg, gv_reg;
    logic [vpb_pkg::FRAC_W-1:0]      fu_reg, fv_reg;
    logic [vpb_pkg::PLANE_W-1:0]     pl_reg;
    logic [vpb_pkg::BL_W-1:0]        rb_reg;
    logic [vpb_pkg::CNT_W-1:0]       rc_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == B_IDLE) && !empty;

    // table view of the current point's plane
    logic                        pt_open;
    logic                        pt_split;
    logic [vpb_pkg::BL_W-1:0]    pt_base;
    logic [vpb_pkg::CNT_W-1:0]   pt_cnt;
    always_comb begin
        pt_open  = open_reg[cur_reg.pl];
        pt_base  = base_reg[cur_reg.pl];
        pt_cnt   = cnt_reg[cur_reg.pl];
        pt_split = pt_open && (pt_base != cur_reg.bl);
    end

    // flush scan view
    logic                        fl_open;
    logic                        fl_last;
    logic                        fl_end;
    always_comb begin
        fl_open = open_reg[scan_reg];
        fl_end  = (scan_reg == vpb_pkg::PLANE_W'(vpb_pkg::PLANES - 1));
        fl_last = (((open_reg >> scan_reg) >> 1) == '0)
                  || (nres_reg == vpb_pkg::NRES_W'(vpb_pkg::MAX_RESULTS - 1));
    end

    logic emit;
    assign emit = out_free && (((state_reg == B_PT)) || ((state_reg == B_FL) && fl_open));

    // sequencer and run table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            open_reg  <= '0;
            scan_reg  <= '0;
            nres_reg  <= '0;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (!empty) begin
                        scan_reg  <= '0;
                        nres_reg  <= '0;
                        state_reg <= (head.cmd == vpb_pkg::CMD_FLUSH) ? B_FL : B_PT;
                    end
                end
                B_PT: begin
                    if (out_free) begin
                        if (pt_split) begin
                            open_reg[cur_reg.pl] <= 1'b0;
                        end else begin
                            open_reg[cur_reg.pl] <= 1'b1;
                            state_reg            <= B_IDLE;
                        end
                    end
                end
                B_FL: begin
                    if (fl_open) begin
                        if (out_free) begin
                            open_reg[scan_reg] <= 1'b0;
                            nres_reg           <= nres_reg + 1'b1;
                            scan_reg           <= scan_reg + 1'b1;
                            if (fl_last || fl_end) begin
                                state_reg <= B_IDLE;
                            end
                        end
                    end else if (fl_end) begin
                        state_reg <= B_IDLE;
                    end else begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    // baseline and count entries
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end
        if (state_reg == B_PT && out_free && !pt_split) begin
            if (!pt_open) begin
                base_reg[cur_reg.pl] <= cur_reg.bl;
                cnt_reg[cur_reg.pl]  <= vpb_pkg::CNT_W'(1);
            end else if (pt_cnt != vpb_pkg::COUNT_MAX) begin
                cnt_reg[cur_reg.pl]  <= pt_cnt + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            if (state_reg == B_FL) begin
                kind_reg <= vpb_pkg::KIND_RUN;
                gu_reg   <= '0;
                gv_reg   <= '0;
                fu_reg   <= '0;
                fv_reg   <= '0;
                pl_reg   <= scan_reg;
                rb_reg   <= base_reg[scan_reg];
                rc_reg   <= cnt_reg[scan_reg];
                last_reg <= fl_last;
            end else if (pt_split) begin
                kind_reg <= vpb_pkg::KIND_RUN;
                gu_reg   <= '0;
                gv_reg   <= '0;
                fu_reg   <= '0;
                fv_reg   <= '0;
                pl_reg   <= cur_reg.pl;
                rb_reg   <= pt_base;
                rc_reg   <= pt_cnt;
                last_reg <= 1'b0;
            end else begin
                kind_reg <= vpb_pkg::KIND_POINT;
                gu_reg   <= cur_reg.gu;
                gv_reg   <= cur_reg.gv;
                fu_reg   <= cur_reg.fu;
                fv_reg   <= cur_reg.fv;
                pl_reg   <= cur_reg.pl;
                rb_reg   <= '0;
                rc_reg   <= '0;
                last_reg <= 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_grid_u       = gu_reg;
    assign m_grid_v       = gv_reg;
    assign m_plane_index  = pl_reg;
    assign m_frac_u       = fu_reg;
    assign m_frac_v       = fv_reg;
    assign m_run_baseline = rb_reg;
    assign m_run_count    = rc_reg;
    assign m_last         = last_reg;

    // a point leaves its plane open behind it
    a_point_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_PT && out_free && !pt_split) |=> open_reg[$past(cur_reg.pl)])
        else $error("plane not open after point");

    // a point result always closes its input
    a_point_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == vpb_pkg::KIND_POINT) |-> last_reg)
        else $error("point result without last");

    // a descriptor only comes from a plane that was open, and leaves it closed
    a_run_from_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (state_reg == B_FL || pt_split)) |=> !open_reg[pl_reg])
        else $error("descriptor plane still open");

endmodule

### hw/rtl/visibility_pregrid_wplane_binner.sv
// ---------------------------------------------------------------------------
// visibility_pregrid_wplane_binner
// scales visibility coordinates into grid cells and w planes and tracks
// per-plane baseline runs
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    command, coords, channel, baseline
// m_        out        m_valid/m_ready    kind, cells, fractions, plane, run
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// a point makes up to seven passes of the shared bit-serial multiplier in the
// front. a flush scans one plane per cycle, 32 at most, in the back, waiting
// on an open plane while the output is held. front and back run apart
// through a two-entry queue; the output register holds a result while m_ready
// is low and the front keeps working until the queue is full. reset clears
// the plane table valid bits and state registers and resets the configuration.
// ---------------------------------------------------------------------------
module visibility_pregrid_wplane_binner (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [31:0] s_coord_u,
    input  logic signed [31:0] s_coord_v,
    input  logic signed [31:0] s_coord_w,
    input  logic [15:0]        s_channel_index,
    input  logic [15:0]        s_baseline_id,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [11:0]        m_grid_u,
    output logic [11:0]        m_grid_v,
    output logic [4:0]         m_plane_index,
    output logic [2:0]         m_frac_u,
    output logic [2:0]         m_frac_v,
    output logic [15:0]        m_run_baseline,
    output logic [23:0]        m_run_count,
    output logic               m_last
);

    vpb_pkg::cfg_t  cfg_reg;
    logic           push, full, pop, empty;
    vpb_pkg::item_t push_data, head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale    <= 32'd65536;
            cfg_reg.uv_off   <= '0;
            cfg_reg.w_off    <= '0;
            cfg_reg.ratio    <= '0;
            cfg_reg.inv_step <= 32'd65536;
        end else if (cfg_we) begin
            case (cfg_index)
                vpb_pkg::REG_COORD_SCALE: cfg_reg.scale    <= cfg_wdata;
                vpb_pkg::REG_UV_OFFSET:   cfg_reg.uv_off   <= cfg_wdata;
                vpb_pkg::REG_W_OFFSET:    cfg_reg.w_off    <= cfg_wdata;
                vpb_pkg::REG_CHAN_RATIO:  cfg_reg.ratio    <= cfg_wdata;
                vpb_pkg::REG_INV_STEP:    cfg_reg.inv_step <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vpb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_coord_u       (s_coord_u),
        .s_coord_v       (s_coord_v),
        .s_coord_w       (s_coord_w),
        .s_channel_index (s_channel_index),
        .s_baseline_id   (s_baseline_id),
        .push            (push),
        .push_data       (push_data),
        .full            (full)
    );

    vpb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    vpb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (empty),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_grid_u       (m_grid_u),
        .m_grid_v       (m_grid_v),
        .m_plane_index  (m_plane_index),
        .m_frac_u       (m_frac_u),
        .m_frac_v       (m_frac_v),
        .m_run_baseline (m_run_baseline),
        .m_run_count    (m_run_count),
        .m_last         (m_last)
    );

endmodule
